FILE: design/ata_pkg.sv
// Shared constants and the arctangent table for the accelerometer tilt pipeline.
package ata_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int ANGLE_TABLE_LEN  = 24;
  localparam int CORDIC_STEPS     = (ANGLE_ITERATIONS > ANGLE_TABLE_LEN) ?
                                    ANGLE_TABLE_LEN : ANGLE_ITERATIONS;

  localparam int SAMPLE_W    = 16;
  localparam int TILT_W      = 15;
  localparam int SQ_W        = 32;
  localparam int MAG_FRAC    = 12;
  localparam int ANGLE_FRAC  = 16;
  localparam int RAD_W       = SQ_W + 2 * MAG_FRAC;
  localparam int SQRT_STAGES = RAD_W / 2;
  localparam int ROOT_W      = SQRT_STAGES;
  localparam int REM_W       = ROOT_W + 2;
  localparam int XY_W        = 31;
  localparam int Z_W         = 32;

  localparam int TILT_LIMIT  = 9000;

  // Squares, square-root steps, CORDIC steps, rounding
  localparam int LANE_STAGES = 1 + SQRT_STAGES + CORDIC_STEPS + 1;

  // atan(2^-i) in units of 2^-16 hundredths of a degree
  localparam logic signed [Z_W-1:0] ATAN_TABLE [ANGLE_TABLE_LEN] = '{
    32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
    32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
    32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
    32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
    32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
    32'sd358,       32'sd179,       32'sd90,       32'sd45
  };

endpackage

FILE: design/ata_in_if.sv
// Input channel carrying one raw accelerometer triple per item.
interface ata_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ata_pkg::SAMPLE_W-1:0]  accel_x;
  logic signed [ata_pkg::SAMPLE_W-1:0]  accel_y;
  logic signed [ata_pkg::SAMPLE_W-1:0]  accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

FILE: design/ata_out_if.sv
// Output channel carrying the three tilt angles of one item.
interface ata_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ata_pkg::TILT_W-1:0]  tilt_x;
  logic signed [ata_pkg::TILT_W-1:0]  tilt_y;
  logic signed [ata_pkg::TILT_W-1:0]  tilt_z;

  modport source (output valid, output tilt_x, output tilt_y, output tilt_z,
                  input ready);
  modport sink   (input valid, input tilt_x, input tilt_y, input tilt_z,
                  output ready);
endinterface

FILE: design/accel_tilt_angles.sv
// Top level: three tilt lanes side by side, zero-sample bypass and output register.
// Path of an item: square register, square-root stages, CORDIC stages, rounding register, output register.
// Throughput: one item per cycle while tilts.ready is high; each lane is a fully pipelined square-root and
// CORDIC chain, and stages with no item fill even while a result waits unread.
// Reset: rst (synchronous) clears the stage valid flags only; data registers
// are not reset.
module accel_tilt_angles (
  input  logic          clk,
  input  logic          rst,
  ata_in_if.sink        samples,
  ata_out_if.source     tilts
);

  localparam int L = ata_pkg::LANE_STAGES;

  logic [L:0]   vld;
  logic [L:0]   ld;
  logic [L-1:0] zflag;
  logic signed [ata_pkg::TILT_W-1:0] tx;
  logic signed [ata_pkg::TILT_W-1:0] ty;
  logic signed [ata_pkg::TILT_W-1:0] tz;
  logic         all_zero;

  // Each stage may load when empty or when the stage after it moves on
  always_comb begin
    ld[L] = !vld[L] || tilts.ready;
    for (int k = L - 1; k >= 0; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign samples.ready = ld[0];
  assign all_zero = (samples.accel_x == '0) && (samples.accel_y == '0) &&
                    (samples.accel_z == '0);

  // Advance the valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= samples.valid;
      end
      for (int k = 1; k <= L; k++) begin
        if (ld[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Carry the all-zero mark beside the lanes
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      zflag[0] <= all_zero;
    end
    for (int k = 1; k < L; k++) begin
      if (ld[k]) begin
        zflag[k] <= zflag[k-1];
      end
    end
  end

  ata_lane u_lane_x (
    .clk  (clk),
    .ld   (ld[L-1:0]),
    .a    (samples.accel_x),
    .b    (samples.accel_y),
    .c    (samples.accel_z),
    .tilt (tx)
  );

  ata_lane u_lane_y (
    .clk  (clk),
    .ld   (ld[L-1:0]),
    .a    (samples.accel_y),
    .b    (samples.accel_x),
    .c    (samples.accel_z),
    .tilt (ty)
  );

  ata_lane u_lane_z (
    .clk  (clk),
    .ld   (ld[L-1:0]),
    .a    (samples.accel_z),
    .b    (samples.accel_x),
    .c    (samples.accel_y),
    .tilt (tz)
  );

  // Merge lanes into the output register, forcing zero for an all-zero item
  always_ff @(posedge clk) begin
    if (ld[L]) begin
      tilts.tilt_x <= zflag[L-1] ? '0 : tx;
      tilts.tilt_y <= zflag[L-1] ? '0 : ty;
      tilts.tilt_z <= zflag[L-1] ? '0 : tz;
    end
  end

  assign tilts.valid = vld[L];

endmodule

FILE: design/ata_lane.sv
// One tilt lane: squares, pipelined integer square root, CORDIC arctangent, rounding.
module ata_lane (
  input  logic                                   clk,
  input  logic [ata_pkg::LANE_STAGES-1:0]        ld,
  input  logic signed [ata_pkg::SAMPLE_W-1:0]    a,
  input  logic signed [ata_pkg::SAMPLE_W-1:0]    b,
  input  logic signed [ata_pkg::SAMPLE_W-1:0]    c,
  output logic signed [ata_pkg::TILT_W-1:0]      tilt
);

  localparam int SQ  = ata_pkg::SQRT_STAGES;
  localparam int CS  = ata_pkg::CORDIC_STEPS;
  localparam int CB  = 1 + SQ;
  localparam int RS  = ata_pkg::LANE_STAGES - 1;

  // Square stage
  logic [ata_pkg::SQ_W-1:0]              sqb;
  logic [ata_pkg::SQ_W-1:0]              sqc;
  logic signed [ata_pkg::SAMPLE_W-1:0]   a0;
  logic signed [ata_pkg::SQ_W-1:0]       pb;
  logic signed [ata_pkg::SQ_W-1:0]       pc;

  assign pb = ata_pkg::SQ_W'(b) * ata_pkg::SQ_W'(b);
  assign pc = ata_pkg::SQ_W'(c) * ata_pkg::SQ_W'(c);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      sqb <= pb;
      sqc <= pc;
      a0  <= a;
    end
  end

  // Square-root stages: one root bit per stage
  logic [ata_pkg::RAD_W-1:0]             rad  [SQ+1];
  logic [ata_pkg::ROOT_W-1:0]            root [SQ+1];
  logic [ata_pkg::REM_W-1:0]             rem  [SQ+1];
  logic signed [ata_pkg::SAMPLE_W-1:0]   ad   [SQ+1];

  assign rad[0]  = {sqb + sqc, (2 * ata_pkg::MAG_FRAC)'(0)};
  assign root[0] = '0;
  assign rem[0]  = '0;
  assign ad[0]   = a0;

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    logic [ata_pkg::REM_W+1:0] rem_sh;
    logic [ata_pkg::REM_W+1:0] trial;
    logic                      fits;

    assign rem_sh = {rem[j], rad[j][ata_pkg::RAD_W-1 -: 2]};
    assign trial  = {2'b00, root[j], 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (ld[1+j]) begin
        rad[j+1]  <= {rad[j][ata_pkg::RAD_W-3:0], 2'b00};
        root[j+1] <= {root[j][ata_pkg::ROOT_W-2:0], fits};
        rem[j+1]  <= fits ? ata_pkg::REM_W'(rem_sh - trial) : ata_pkg::REM_W'(rem_sh);
        ad[j+1]   <= ad[j];
      end
    end
  end

  // CORDIC vectoring stages
  logic signed [ata_pkg::XY_W-1:0]  cx [CS+1];
  logic signed [ata_pkg::XY_W-1:0]  cy [CS+1];
  logic signed [ata_pkg::Z_W-1:0]   cz [CS+1];

  assign cx[0] = ata_pkg::XY_W'(root[SQ]);
  // Sign-extend the scaled own-axis sample
  assign cy[0] = ata_pkg::XY_W'(signed'({ad[SQ], ata_pkg::MAG_FRAC'(0)}));
  assign cz[0] = '0;

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    logic signed [ata_pkg::XY_W-1:0] xs;
    logic signed [ata_pkg::XY_W-1:0] ys;

    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;

    always_ff @(posedge clk) begin
      if (ld[CB+i]) begin
        if (!cy[i][ata_pkg::XY_W-1]) begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + ata_pkg::ATAN_TABLE[i];
        end else begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - ata_pkg::ATAN_TABLE[i];
        end
      end
    end
  end

  // Round to nearest and clamp to a quarter turn
  logic signed [ata_pkg::Z_W:0]                 zr;
  logic signed [ata_pkg::Z_W-ata_pkg::ANGLE_FRAC:0] rq;
  logic signed [ata_pkg::TILT_W-1:0]            tilt_next;

  assign zr = (ata_pkg::Z_W+1)'(cz[CS]) + (ata_pkg::Z_W+1)'(1 <<< (ata_pkg::ANGLE_FRAC-1));
  assign rq = zr[ata_pkg::Z_W:ata_pkg::ANGLE_FRAC];

  always_comb begin
    if (rq > (ata_pkg::Z_W-ata_pkg::ANGLE_FRAC+1)'(ata_pkg::TILT_LIMIT)) begin
      tilt_next = ata_pkg::TILT_W'(ata_pkg::TILT_LIMIT);
    end else if (rq < -(ata_pkg::Z_W-ata_pkg::ANGLE_FRAC+1)'(ata_pkg::TILT_LIMIT)) begin
      tilt_next = -ata_pkg::TILT_W'(ata_pkg::TILT_LIMIT);
    end else begin
      tilt_next = ata_pkg::TILT_W'(rq);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[RS]) begin
      tilt <= tilt_next;
    end
  end

endmodule
